// ===== sv/reversible_ring_queue_macros.svh =====
// ----------------------------------------------------------------------------
// Reversible ring queue assertion macros
// Shared property wrappers, sampled on clk and masked while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef REVERSIBLE_RING_QUEUE_MACROS_SVH
`define REVERSIBLE_RING_QUEUE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define RRQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/rrq_pkg.sv =====
// ----------------------------------------------------------------------------
// Reversible ring queue package
// Sizes, request codes, index helpers and the status bundle of the queue.
// ----------------------------------------------------------------------------
package rrq_pkg;

	localparam int DEPTH  = 64;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = 7;
	localparam int DATA_W = 32;
	localparam int MODE_W = 2;

	localparam logic [MODE_W-1:0] MODE_ENQ = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DEQ = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REV = 2'd2;

	localparam logic [DATA_W-1:0] INT_MIN = 32'h8000_0000;

	typedef struct packed {
		logic              valid_s1;
		logic [DATA_W-1:0] head_value;
		logic [CNT_W-1:0]  count;
		logic              is_empty;
		logic              is_full;
		logic              done;
	} rrq_res_t;

	// register value saturated to 1..DEPTH
	function automatic logic [CNT_W-1:0] eff_cap(input logic [CNT_W-1:0] w);
		if (w == '0)
			return CNT_W'(1);
		else if (w > CNT_W'(DEPTH))
			return CNT_W'(DEPTH);
		else
			return w;
	endfunction

	function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i,
		input logic [CNT_W-1:0] cap);
		logic [CNT_W-1:0] nxt;
		nxt = CNT_W'(i) + CNT_W'(1);
		return (nxt >= cap) ? '0 : IDX_W'(nxt);
	endfunction

	function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i,
		input logic [CNT_W-1:0] cap);
		return (i == '0) ? IDX_W'(cap - CNT_W'(1)) : i - IDX_W'(1);
	endfunction

endpackage

// ===== sv/reversible_ring_queue.sv =====
// Results pass the storage read stage, then the output register.
// Throughput: one request per cycle while req_stall is low; the storage RAM has one write and one read port per cycle.
// Back-pressure on the result side stalls requests only once the output and read stages are full.
// Reset: asynchronous, empty queue, forward order, capacity 64; storage contents undefined.
// A capacity write empties the queue; no clearing pass, the block is ready straight away.
// ----------------------------------------------------------------------------
// Reversible ring queue
// Bounded circular FIFO of signed words with enqueue, dequeue and reverse.
// ----------------------------------------------------------------------------
`include "reversible_ring_queue_macros.svh"

module reversible_ring_queue (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [rrq_pkg::CNT_W-1:0]         wr_data,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic [rrq_pkg::MODE_W-1:0]        mode,
	input  logic signed [rrq_pkg::DATA_W-1:0] value,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic signed [rrq_pkg::DATA_W-1:0] head_value,
	output logic [rrq_pkg::CNT_W-1:0]         count,
	output logic                              is_empty,
	output logic                              is_full,
	output logic                              done_res
);

	rrq_pkg::rrq_res_t res;
	logic              fire, take;
	logic              rsp_valid_q;

	assign take      = res.valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = res.valid_s1 && !take;
	assign fire      = req_valid && !req_stall;

	rrq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (wr_data),
		.fire    (fire),
		.take    (take),
		.mode    (mode),
		.value   (value),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (take)
			rsp_valid_q <= 1'b1;
		else if (!rsp_stall)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			head_value <= res.head_value;
			count      <= res.count;
			is_empty   <= res.is_empty;
			is_full    <= res.is_full;
			done_res   <= res.done;
		end
	end

	assign rsp_valid = rsp_valid_q;

	`RRQ_ASSERT_NEXT(a_fire_fills_s1, fire, res.valid_s1, "accepted request lost before read stage")
	`RRQ_ASSERT_NOW(a_empty_count, rsp_valid_q, is_empty == (count == '0), "empty flag disagrees with count")
	`RRQ_ASSERT_NOW(a_empty_min, rsp_valid_q && is_empty, head_value == rrq_pkg::INT_MIN, "empty queue front not most negative")
	`RRQ_ASSERT_NOW(a_full_not_empty, rsp_valid_q, !(is_full && is_empty), "queue reported full and empty")

endmodule

// ===== sv/rrq_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered, no reset on contents.
// ----------------------------------------------------------------------------
module rrq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// ===== sv/rrq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Reversible ring queue control
// Pointer, count and direction update, storage write and front lookup.
// ----------------------------------------------------------------------------
module rrq_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [rrq_pkg::CNT_W-1:0]     wr_data,
	input  logic                          fire,
	input  logic                          take,
	input  logic [rrq_pkg::MODE_W-1:0]    mode,
	input  logic [rrq_pkg::DATA_W-1:0]    value,
	output rrq_pkg::rrq_res_t             res
);

	logic [rrq_pkg::CNT_W-1:0]  cap_q;
	logic [rrq_pkg::IDX_W-1:0]  head_q, tail_q;
	logic [rrq_pkg::CNT_W-1:0]  cnt_q;
	logic                       rev_q;

	logic [rrq_pkg::IDX_W-1:0]  head_n, tail_n, waddr, front_idx;
	logic [rrq_pkg::CNT_W-1:0]  cnt_n, new_cap;
	logic                       rev_n, enq_ok, done_n, mem_we;

	logic                       valid_s1, full_s1, done_s1, fwd_s1;
	logic [rrq_pkg::CNT_W-1:0]  cnt_s1;
	logic [rrq_pkg::DATA_W-1:0] fwd_data_s1, rdata;

	always_comb begin
		head_n = head_q;
		tail_n = tail_q;
		cnt_n  = cnt_q;
		rev_n  = rev_q;
		enq_ok = 1'b0;
		done_n = 1'b0;
		waddr  = tail_q;
		case (mode)
			rrq_pkg::MODE_ENQ: begin
				if (cnt_q < cap_q) begin
					// reversed: rear sits at head, grows backwards
					if (rev_q) begin
						head_n = rrq_pkg::idx_dec(head_q, cap_q);
						waddr  = head_n;
					end else begin
						tail_n = rrq_pkg::idx_inc(tail_q, cap_q);
						waddr  = tail_n;
					end
					cnt_n  = cnt_q + rrq_pkg::CNT_W'(1);
					enq_ok = 1'b1;
					done_n = 1'b1;
				end
			end
			rrq_pkg::MODE_DEQ: begin
				if (cnt_q != '0) begin
					if (rev_q)
						tail_n = rrq_pkg::idx_dec(tail_q, cap_q);
					else
						head_n = rrq_pkg::idx_inc(head_q, cap_q);
					cnt_n  = cnt_q - rrq_pkg::CNT_W'(1);
					done_n = 1'b1;
				end
			end
			rrq_pkg::MODE_REV: begin
				rev_n  = !rev_q;
				done_n = 1'b1;
			end
			default: begin
			end
		endcase
		front_idx = rev_n ? tail_n : head_n;
		mem_we    = fire && enq_ok;
		new_cap   = rrq_pkg::eff_cap(wr_data);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= rrq_pkg::CNT_W'(rrq_pkg::DEPTH);
			head_q <= '0;
			tail_q <= rrq_pkg::IDX_W'(rrq_pkg::DEPTH - 1);
			cnt_q  <= '0;
			rev_q  <= 1'b0;
		end else if (wr_en) begin
			cap_q  <= new_cap;
			head_q <= '0;
			tail_q <= rrq_pkg::IDX_W'(new_cap - rrq_pkg::CNT_W'(1));
			cnt_q  <= '0;
			rev_q  <= 1'b0;
		end else if (fire) begin
			head_q <= head_n;
			tail_q <= tail_n;
			cnt_q  <= cnt_n;
			rev_q  <= rev_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (fire)
			valid_s1 <= 1'b1;
		else if (take)
			valid_s1 <= 1'b0;
	end

	// write and front read hit the same entry when enqueueing into an empty queue
	always_ff @(posedge clk) begin
		if (fire) begin
			cnt_s1      <= cnt_n;
			full_s1     <= (cnt_n == cap_q);
			done_s1     <= done_n;
			fwd_s1      <= mem_we && (waddr == front_idx);
			fwd_data_s1 <= value;
		end
	end

	rrq_ram #(
		.WIDTH (rrq_pkg::DATA_W),
		.DEPTH (rrq_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (waddr),
		.wdata (value),
		.re    (fire),
		.raddr (front_idx),
		.rdata (rdata)
	);

	always_comb begin
		res.valid_s1   = valid_s1;
		res.count      = cnt_s1;
		res.is_empty   = (cnt_s1 == '0);
		res.is_full    = full_s1;
		res.done       = done_s1;
		if (cnt_s1 == '0)
			res.head_value = rrq_pkg::INT_MIN;
		else if (fwd_s1)
			res.head_value = fwd_data_s1;
		else
			res.head_value = rdata;
	end

endmodule
